// ===== rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and lookup functions for the JSON string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int CHAR_COUNT_W    = 16;
  localparam int CHAR_W          = 7;
  localparam int BYTE_W          = 8;
  localparam int KIND_W          = 2;
  localparam int HEX_ACC_W       = 12;
  localparam int NUM_SHORT_ESC   = 8;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // scanner phase, one-hot
  typedef enum logic [6:0] {
    PH_NORMAL  = 7'b0000001,
    PH_ESCAPE  = 7'b0000010,
    PH_HEX1    = 7'b0000100,
    PH_HEX2    = 7'b0001000,
    PH_HEX3    = 7'b0010000,
    PH_HEX4    = 7'b0100000,
    PH_DISCARD = 7'b1000000
  } phase_t;

  // significant byte values
  localparam logic [BYTE_W-1:0] B_QUOTE     = 8'h22;
  localparam logic [BYTE_W-1:0] B_BACKSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] B_LETTER_U  = 8'h75;

  // short escape letters and the characters they stand for
  localparam logic [BYTE_W-1:0] ESC_LETTER [NUM_SHORT_ESC] =
    '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};
  localparam logic [CHAR_W-1:0] ESC_VALUE [NUM_SHORT_ESC] =
    '{7'h22, 7'h5C, 7'h2F, 7'h08, 7'h0C, 7'h0A, 7'h0D, 7'h09};

  typedef struct packed {
    logic              hit;
    logic [CHAR_W-1:0] value;
  } esc_lookup_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_lookup_t;

  function automatic esc_lookup_t short_escape(input logic [BYTE_W-1:0] b);
    esc_lookup_t r;
    r = '0;
    for (int i = 0; i < NUM_SHORT_ESC; i++) begin
      if (b == ESC_LETTER[i]) begin
        r.hit   = 1'b1;
        r.value = ESC_VALUE[i];
      end
    end
    return r;
  endfunction

  // hex digit value, upper or lower case
  function automatic hex_lookup_t hex_digit(input logic [BYTE_W-1:0] b);
    hex_lookup_t r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.ok    = 1'b1;
      r.value = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r.ok    = 1'b1;
      r.value = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r.ok    = 1'b1;
      r.value = 4'(b - 8'h57);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/jsu_in_if.sv =====
// ----------------------------------------------------------------------------
// jsu_in_if
// Input channel: one string body byte or the end marker per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       is_end;

  modport source (output valid, output byte_in, output is_end, input ready);
  modport sink   (input valid, input byte_in, input is_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/jsu_out_if.sv =====
// ----------------------------------------------------------------------------
// jsu_out_if
// Result channel: decoded character, done or error, with the running count.
// ----------------------------------------------------------------------------
`default_nettype none

interface jsu_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [6:0]  char_out;
  logic [15:0] char_count;

  modport source (output valid, output kind, output char_out, output char_count,
                  input ready);
  modport sink   (input valid, input kind, input char_out, input char_count,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/json_string_unescape_ascii.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_ascii
// Decodes a JSON string body, one byte per transfer, into ASCII characters.
// ----------------------------------------------------------------------------
// Takes one byte per clock and gives at most one result per byte, in the next
// cycle, from a single result register; a new byte is taken every cycle as
// long as the result register is empty or being drained in the same cycle.
// Plain bytes 1..127 other than quote and backslash pass through, the eight
// short escapes and \uXXXX (code 1..127, either hex case) decode to one
// character, and escape leads produce nothing. The first fault in a string
// gives one error result and the rest of the string is dropped silently.
// The end transfer gives done with the final count (or an error if an
// escape was cut short) and returns the scanner to its reset state.
// char_count is the saturating count of decoded characters, low 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_ascii
  import jsu_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  jsu_in_if.sink     item,
  jsu_out_if.source  result
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // scanner state
  phase_t                 phase, phase_next;
  logic [HEX_ACC_W-1:0]   hex_accum, hex_accum_next;
  logic [COUNT_WIDTH-1:0] decoded_count, decoded_count_next;

  // result register
  logic                   res_valid;
  kind_t                  res_kind;
  logic [CHAR_W-1:0]      res_char;
  logic [CHAR_COUNT_W-1:0] res_count;

  // combinational outcome of the current byte
  logic                   emit;
  kind_t                  emit_kind;
  logic [CHAR_W-1:0]      emit_char;
  logic [COUNT_WIDTH-1:0] emit_count;
  logic [CHAR_COUNT_W-1:0] emit_count16;

  logic                   take;
  logic [COUNT_WIDTH-1:0] count_inc;
  esc_lookup_t            esc;
  hex_lookup_t            hex;
  logic [BYTE_W-1:0]      b;

  // The result register frees up when empty or taken this cycle.
  assign item.ready = !res_valid || result.ready;
  assign take       = item.valid && item.ready;

  assign b         = item.byte_in;
  assign esc       = short_escape(b);
  assign hex       = hex_digit(b);
  assign count_inc = (decoded_count == COUNT_MAX) ? decoded_count
                                                  : decoded_count + 1'b1;

  always_comb begin
    phase_next         = phase;
    hex_accum_next     = hex_accum;
    decoded_count_next = decoded_count;
    emit               = 1'b0;
    emit_kind          = KIND_ERROR;
    emit_char          = '0;
    emit_count         = decoded_count;

    if (item.is_end) begin
      // closing quote: done if clean, error if an escape was cut short
      if (phase == PH_NORMAL) begin
        emit      = 1'b1;
        emit_kind = KIND_DONE;
      end else if (phase != PH_DISCARD) begin
        emit      = 1'b1;
        emit_kind = KIND_ERROR;
      end
      phase_next         = PH_NORMAL;
      hex_accum_next     = '0;
      decoded_count_next = '0;
    end else begin
      unique case (phase)
        PH_NORMAL: begin
          if (b == 8'h00 || b[7] || b == B_QUOTE) begin
            emit           = 1'b1;
            phase_next     = PH_DISCARD;
            hex_accum_next = '0;
          end else if (b == B_BACKSLASH) begin
            phase_next = PH_ESCAPE;
          end else begin
            emit               = 1'b1;
            emit_kind          = KIND_CHAR;
            emit_char          = b[CHAR_W-1:0];
            emit_count         = count_inc;
            decoded_count_next = count_inc;
          end
        end
        PH_ESCAPE: begin
          if (esc.hit) begin
            emit               = 1'b1;
            emit_kind          = KIND_CHAR;
            emit_char          = esc.value;
            emit_count         = count_inc;
            decoded_count_next = count_inc;
            phase_next         = PH_NORMAL;
          end else if (b == B_LETTER_U) begin
            phase_next     = PH_HEX1;
            hex_accum_next = '0;
          end else begin
            emit           = 1'b1;
            phase_next     = PH_DISCARD;
            hex_accum_next = '0;
          end
        end
        PH_HEX1, PH_HEX2, PH_HEX3: begin
          if (!hex.ok) begin
            emit           = 1'b1;
            phase_next     = PH_DISCARD;
            hex_accum_next = '0;
          end else begin
            hex_accum_next = {hex_accum[HEX_ACC_W-5:0], hex.value};
            phase_next     = (phase == PH_HEX1) ? PH_HEX2 :
                             (phase == PH_HEX2) ? PH_HEX3 : PH_HEX4;
          end
        end
        PH_HEX4: begin
          // last digit: code must lie in 1..127
          hex_accum_next = '0;
          if (!hex.ok || hex_accum[HEX_ACC_W-1:3] != '0 ||
              {hex_accum[2:0], hex.value} == 7'd0) begin
            emit       = 1'b1;
            phase_next = PH_DISCARD;
          end else begin
            emit               = 1'b1;
            emit_kind          = KIND_CHAR;
            emit_char          = {hex_accum[2:0], hex.value};
            emit_count         = count_inc;
            decoded_count_next = count_inc;
            phase_next         = PH_NORMAL;
          end
        end
        default: begin
          // discarding until the end transfer
          phase_next = PH_DISCARD;
        end
      endcase
    end
  end

  // count presented as its low 16 bits
  generate
    if (COUNT_WIDTH >= CHAR_COUNT_W) begin : g_cnt_trunc
      assign emit_count16 = emit_count[CHAR_COUNT_W-1:0];
    end else begin : g_cnt_ext
      assign emit_count16 = {{(CHAR_COUNT_W-COUNT_WIDTH){1'b0}}, emit_count};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_NORMAL;
      hex_accum     <= '0;
      decoded_count <= '0;
    end else if (take) begin
      phase         <= phase_next;
      hex_accum     <= hex_accum_next;
      decoded_count <= decoded_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= emit;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // payload, loaded with every transfer that yields a result
  always_ff @(posedge clk) begin
    if (take && emit) begin
      res_kind  <= emit_kind;
      res_char  <= emit_char;
      res_count <= emit_count16;
    end
  end

  assign result.valid      = res_valid;
  assign result.kind       = res_kind;
  assign result.char_out   = res_char;
  assign result.char_count = res_count;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the JSON string body unescaper.
// ----------------------------------------------------------------------------
// A table of directed transfers comes first: plain-byte extremes, a lowercase
// \u escape, and several kinds of fault with an error result and the silence that
// follows it. Random strings come next. Most are well formed, made of plain
// bytes, short escapes and \u escapes. Some carry faults and noise. Every
// accepted byte runs through a local scanner model, and the result channel
// is checked against it field by field, in order. Both channels idle at
// random, and the result side holds off once for a long stretch so that the
// input backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import jsu_pkg::*;

  localparam int RANDOM_ITEMS = 700;     // live transfers in the random part
  localparam int HOLD_AT      = 250;     // live transfers before the hold-off
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 8;
  localparam int TIME_LIMIT   = 5_000_000;  // ns
  localparam int NUM_ROWS     = 25;

  // one result as it should appear on the result channel
  typedef struct packed {
    kind_t                   kind;
    logic [CHAR_W-1:0]       ch;
    logic [CHAR_COUNT_W-1:0] cnt;
  } decode_t;

  // directed row: the transfer, plus a typed-in result where fixed is set
  typedef struct packed {
    logic [BYTE_W-1:0]       b;
    logic                    e;
    logic                    fixed;
    logic                    has;
    kind_t                   kind;
    logic [CHAR_W-1:0]       ch;
    logic [CHAR_COUNT_W-1:0] cnt;
  } dir_row_t;

  logic clk;
  logic rst;

  jsu_in_if  item_ch ();
  jsu_out_if res_ch ();

  json_string_unescape_ascii DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Scanner model: phase, partial \u value and the saturating count
  // --------------------------------------------------------------------------
  phase_t                     sc_phase;
  logic [HEX_ACC_W-1:0]       sc_hex;
  logic [COUNT_WIDTH_DEF-1:0] sc_count;

  decode_t decode_due [$];   // results still owed by the block, oldest first

  int  fails;
  int  accepted;
  int  live_items;           // transfers not swallowed by discarding
  int  n_chars;
  int  n_done;
  int  n_err;
  bit  quiet_run;            // no idling on either side while set
  bit  hold_asked;

  // Advances the model by one accepted transfer; returns 1 with r filled in
  // when the transfer produces a result.
  function automatic bit unescape_step(input logic [BYTE_W-1:0] b, input logic e,
                                       output decode_t r);
    logic [3:0]        dv;
    bit                dok;
    logic [15:0]       code;
    bit                emit;
    bit                fault;
    bit                got;
    logic [CHAR_W-1:0] ch;
    emit  = 1'b0;
    fault = 1'b0;
    got   = 1'b0;
    ch    = '0;
    dv    = '0;
    dok   = 1'b0;
    r.kind = KIND_CHAR;
    r.ch   = '0;
    r.cnt  = sc_count[CHAR_COUNT_W-1:0];

    // closing quote: done when clean, error when an escape is cut short,
    // nothing when the string already faulted; state always clears
    if (e) begin
      got = 1'b1;
      if (sc_phase == PH_NORMAL) begin
        r.kind = KIND_DONE;
      end else if (sc_phase == PH_DISCARD) begin
        got = 1'b0;
      end else begin
        r.kind = KIND_ERROR;
      end
      sc_phase = PH_NORMAL;
      sc_hex   = '0;
      sc_count = '0;
      return got;
    end

    if (b inside {["0":"9"]}) begin
      dok = 1'b1;
      dv  = 4'(b - "0");
    end else if (b inside {["A":"F"]}) begin
      dok = 1'b1;
      dv  = 4'(b - "A" + 8'd10);
    end else if (b inside {["a":"f"]}) begin
      dok = 1'b1;
      dv  = 4'(b - "a" + 8'd10);
    end

    case (sc_phase)
      PH_NORMAL: begin
        // NUL, top-bit bytes and a bare quote are not legal in the body
        if (b == 8'h00 || b[7] || b == B_QUOTE) begin
          fault = 1'b1;
        end else if (b == B_BACKSLASH) begin
          sc_phase = PH_ESCAPE;
        end else begin
          emit = 1'b1;
          ch   = b[CHAR_W-1:0];
        end
      end
      PH_ESCAPE: begin
        emit = 1'b1;
        case (b)
          B_QUOTE, B_BACKSLASH, "/": ch = b[CHAR_W-1:0];
          "b": ch = 7'h08;
          "f": ch = 7'h0C;
          "n": ch = 7'h0A;
          "r": ch = 7'h0D;
          "t": ch = 7'h09;
          B_LETTER_U: begin
            emit     = 1'b0;
            sc_phase = PH_HEX1;
            sc_hex   = '0;
          end
          default: begin
            emit  = 1'b0;
            fault = 1'b1;
          end
        endcase
      end
      PH_HEX1, PH_HEX2, PH_HEX3: begin
        if (!dok) begin
          fault = 1'b1;
        end else begin
          sc_hex = {sc_hex[HEX_ACC_W-5:0], dv};
          if (sc_phase == PH_HEX1) begin
            sc_phase = PH_HEX2;
          end else if (sc_phase == PH_HEX2) begin
            sc_phase = PH_HEX3;
          end else begin
            sc_phase = PH_HEX4;
          end
        end
      end
      PH_HEX4: begin
        if (!dok) begin
          fault = 1'b1;
        end else begin
          code   = {sc_hex, dv};
          sc_hex = '0;
          // only 1..127 is ASCII proper
          if (code == 16'd0 || code > 16'd127) begin
            fault = 1'b1;
          end else begin
            emit = 1'b1;
            ch   = code[CHAR_W-1:0];
          end
        end
      end
      default: ;  // discarding until the closing quote
    endcase

    if (fault) begin
      sc_phase = PH_DISCARD;
      sc_hex   = '0;
      r.kind   = KIND_ERROR;
      r.cnt    = sc_count[CHAR_COUNT_W-1:0];
      got      = 1'b1;
    end else if (emit) begin
      if (sc_count != '1) sc_count++;
      sc_phase = PH_NORMAL;
      r.ch     = ch;
      r.cnt    = sc_count[CHAR_COUNT_W-1:0];
      got      = 1'b1;
    end
    return got;
  endfunction

  // --------------------------------------------------------------------------
  // Idling: mostly none or short, now and then long
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int p;
    if (quiet_run) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return "0" + 8'(v);
    // either case is legal, so mix them
    if ($urandom_range(0, 1) == 1) return "a" + 8'(v) - 8'd10;
    return "A" + 8'(v) - 8'd10;
  endfunction

  // --------------------------------------------------------------------------
  // Byte transfers
  // --------------------------------------------------------------------------
  // Offers one transfer after a random gap and returns once it is taken. The
  // valid line stays high between back-to-back transfers; it is only dropped
  // when a gap is due, so it never goes low and high in one step.
  task automatic send_item(input logic [BYTE_W-1:0] b, input logic e,
                           output bit has, output decode_t r);
    int g;
    g = pick_gap();
    if (g != 0) begin
      item_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.byte_in <= b;
    item_ch.is_end  <= e;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    accepted++;
    if (e || sc_phase != PH_DISCARD) live_items++;
    has = unescape_step(b, e, r);
  endtask

  task automatic send_pred(input logic [BYTE_W-1:0] b, input logic e);
    bit      has;
    decode_t r;
    send_item(b, e, has, r);
    if (has) decode_due.push_back(r);
  endtask

  task automatic send_unicode(input logic [15:0] code);
    send_pred(B_BACKSLASH, 1'b0);
    send_pred(B_LETTER_U, 1'b0);
    for (int i = 3; i >= 0; i--) send_pred(hex_char(code[i*4 +: 4]), 1'b0);
  endtask

  // One random string body and its closing quote. Clean strings hold only
  // legal content; dirty ones mix in faults and raw noise.
  task automatic send_string(input bit dirty);
    int                n;
    int                t;
    logic [BYTE_W-1:0] b;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
    for (int i = 0; i < n; i++) begin
      t = $urandom_range(0, 99);
      if (dirty && t >= 85) begin
        case ($urandom_range(0, 6))
          0: begin
            // illegal plain byte
            case ($urandom_range(0, 2))
              0:       b = 8'h00;
              1:       b = B_QUOTE;
              default: b = 8'($urandom_range(128, 255));
            endcase
            send_pred(b, 1'b0);
          end
          1: begin
            // unknown escape letter
            send_pred(B_BACKSLASH, 1'b0);
            do b = 8'($urandom_range(0, 255));
            while (b inside {B_QUOTE, B_BACKSLASH, "/", "b", "f", "n", "r", "t",
                             B_LETTER_U});
            send_pred(b, 1'b0);
          end
          2: begin
            // non-hex byte somewhere in the four digits
            send_pred(B_BACKSLASH, 1'b0);
            send_pred(B_LETTER_U, 1'b0);
            repeat ($urandom_range(0, 3)) send_pred(hex_char(4'($urandom_range(0, 15))), 1'b0);
            do b = 8'($urandom_range(0, 255));
            while (b inside {["0":"9"], ["A":"F"], ["a":"f"]});
            send_pred(b, 1'b0);
          end
          3: send_unicode(16'h0000);
          4: send_unicode(16'($urandom_range(128, 65535)));
          5: begin
            // closing quote lands inside an escape
            send_pred(B_BACKSLASH, 1'b0);
            if ($urandom_range(0, 1) == 1) begin
              send_pred(B_LETTER_U, 1'b0);
              repeat ($urandom_range(0, 3))
                send_pred(hex_char(4'($urandom_range(0, 15))), 1'b0);
            end
            send_pred(8'($urandom_range(0, 255)), 1'b1);
            return;
          end
          default: send_pred(8'($urandom_range(0, 255)), 1'b0);
        endcase
      end else if (t < 45) begin
        do b = 8'($urandom_range(1, 127));
        while (b == B_QUOTE || b == B_BACKSLASH);
        send_pred(b, 1'b0);
      end else if (t < 70) begin
        send_pred(B_BACKSLASH, 1'b0);
        case ($urandom_range(0, 7))
          0:       b = B_QUOTE;
          1:       b = B_BACKSLASH;
          2:       b = "/";
          3:       b = "b";
          4:       b = "f";
          5:       b = "n";
          6:       b = "r";
          default: b = "t";
        endcase
        send_pred(b, 1'b0);
      end else begin
        send_unicode(16'($urandom_range(1, 127)));
      end
    end
    // the byte under the end marker is don't-care, so randomise it
    send_pred(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    int g;
    bit hold_given;
    stall        = 0;
    hold_given   = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (hold_asked && !hold_given) begin
        // block fills up behind this and must stall its input
        hold_given = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall > 0) begin
        stall--;
        res_ch.ready <= 1'b0;
      end else begin
        g = pick_gap();
        if (g == 0) begin
          res_ch.ready <= 1'b1;
        end else begin
          stall = g - 1;
          res_ch.ready <= 1'b0;
        end
      end
    end
  end

  // every result transfer is matched against the oldest outstanding one
  always @(posedge clk) begin
    decode_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (decode_due.size() == 0) begin
        $error("unexpected result: kind %0d char %0h count %0d",
               res_ch.kind, res_ch.char_out, res_ch.char_count);
        fails++;
      end else begin
        want = decode_due.pop_front();
        if (res_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, res_ch.kind);
          fails++;
        end
        if (res_ch.char_out !== want.ch) begin
          $error("char_out: expected %0h, got %0h", want.ch, res_ch.char_out);
          fails++;
        end
        if (res_ch.char_count !== want.cnt) begin
          $error("char_count: expected %0d, got %0d", want.cnt, res_ch.char_count);
          fails++;
        end
        case (want.kind)
          KIND_CHAR: n_chars++;
          KIND_DONE: n_done++;
          default:   n_err++;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  dir_row_t dir_rows [NUM_ROWS];

  initial begin
    bit      has;
    decode_t r;
    decode_t typed;

    // directed table; rows with fixed clear are left to the model
    dir_rows = '{
      // plain-byte extremes straight after reset
      '{"A",         1'b0, 1'b1, 1'b1, KIND_CHAR,  7'h41, 16'd1},
      '{8'h01,       1'b0, 1'b1, 1'b1, KIND_CHAR,  7'h01, 16'd2},
      '{8'h7F,       1'b0, 1'b1, 1'b1, KIND_CHAR,  7'h7F, 16'd3},
      // short escape, then \u007f with a lowercase digit
      '{B_BACKSLASH, 1'b0, 1'b1, 1'b0, KIND_CHAR,  7'h00, 16'd0},
      '{"n",         1'b0, 1'b0, 1'b0, KIND_CHAR,  7'h00, 16'd0},
      '{B_BACKSLASH, 1'b0, 1'b0, 1'b0, KIND_CHAR,  7'h00, 16'd0},
      '{B_LETTER_U,  1'b0, 1'b0, 1'b0, KIND_CHAR,  7'h00, 16'd0},
      '{"0",         1'b0, 1'b0, 1'b0, KIND_CHAR,  7'h00, 16'd0},
      '{"0",         1'b0, 1'b0, 1'b0, KIND_CHAR,  7'h00, 16'd0},
      '{"7",         1'b0, 1'b0, 1'b0, KIND_CHAR,  7'h00, 16'd0},
      '{"f",         1'b0, 1'b0, 1'b0, KIND_CHAR,  7'h00, 16'd0},
      '{8'hFF,       1'b1, 1'b1, 1'b1, KIND_DONE,  7'h00, 16'd5},
      // NUL byte faults; the rest of the string and its end stay silent
      '{8'h00,       1'b0, 1'b1, 1'b1, KIND_ERROR, 7'h00, 16'd0},
      '{"A",         1'b0, 1'b1, 1'b0, KIND_CHAR,  7'h00, 16'd0},
      '{8'h00,       1'b1, 1'b1, 1'b0, KIND_CHAR,  7'h00, 16'd0},
      // top-bit byte
      '{8'hFF,       1'b0, 1'b1, 1'b1, KIND_ERROR, 7'h00, 16'd0},
      '{8'h00,       1'b1, 1'b1, 1'b0, KIND_CHAR,  7'h00, 16'd0},
      // bare quote inside the body
      '{B_QUOTE,     1'b0, 1'b1, 1'b1, KIND_ERROR, 7'h00, 16'd0},
      '{8'h00,       1'b1, 1'b1, 1'b0, KIND_CHAR,  7'h00, 16'd0},
      // unknown escape letter
      '{B_BACKSLASH, 1'b0, 1'b1, 1'b0, KIND_CHAR,  7'h00, 16'd0},
      '{"x",         1'b0, 1'b1, 1'b1, KIND_ERROR, 7'h00, 16'd0},
      '{8'h00,       1'b1, 1'b1, 1'b0, KIND_CHAR,  7'h00, 16'd0},
      // string ends straight after a backslash
      '{B_BACKSLASH, 1'b0, 1'b1, 1'b0, KIND_CHAR,  7'h00, 16'd0},
      '{8'h00,       1'b1, 1'b1, 1'b1, KIND_ERROR, 7'h00, 16'd0},
      // empty string
      '{8'h00,       1'b1, 1'b1, 1'b1, KIND_DONE,  7'h00, 16'd0}
    };

    fails      = 0;
    accepted   = 0;
    live_items = 0;
    n_chars    = 0;
    n_done     = 0;
    n_err      = 0;
    quiet_run  = 1'b0;
    hold_asked = 1'b0;
    sc_phase   = PH_NORMAL;
    sc_hex     = '0;
    sc_count   = '0;

    rst             = 1'b1;
    item_ch.valid   = 1'b0;
    item_ch.byte_in = '0;
    item_ch.is_end  = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].b, dir_rows[i].e, has, r);
      if (dir_rows[i].fixed) begin
        if (dir_rows[i].has) begin
          typed.kind = dir_rows[i].kind;
          typed.ch   = dir_rows[i].ch;
          typed.cnt  = dir_rows[i].cnt;
          decode_due.push_back(typed);
        end
      end else if (has) begin
        decode_due.push_back(r);
      end
    end

    // random strings; now and then a run with no idling on either side
    live_items = 0;
    while (live_items < RANDOM_ITEMS) begin
      if (!hold_asked && live_items > HOLD_AT) hold_asked <= 1'b1;
      quiet_run = ($urandom_range(0, 7) == 0);
      send_string($urandom_range(0, 99) < 35);
    end
    quiet_run = 1'b0;

    item_ch.valid <= 1'b0;
    while (decode_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d transfers: %0d characters, %0d clean strings, %0d errors.",
             accepted, n_chars, n_done, n_err);
    $display("Included every fault kind and a %0d-cycle result hold-off.", HOLD_CYCLES);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIME_LIMIT);
    $display("FAIL");
    $finish;
  end

endmodule
